// File: hdl/plmt_pkg.sv
// Shared constants, command and state codes, and control structs for the
// piecewise-linear table block. No dependencies.
`default_nettype none

package plmt_pkg;

  localparam int MAX_STEPS = 256;
  localparam int FRAC_BITS = 16;
  localparam int DEPTH     = MAX_STEPS + 1;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int STEP_W    = 9;
  localparam int TOL_W     = 16;
  localparam int VAL_W     = 32;
  localparam int X_W       = FRAC_BITS + 1;
  localparam int P_W       = FRAC_BITS + STEP_W;
  localparam int DIFF_W    = VAL_W + 1;
  localparam int PROD_W    = DIFF_W + FRAC_BITS + 1;
  localparam logic [VAL_W-1:0] ONE_Q = VAL_W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_EVAL   = 2'd1,
    CMD_VERIFY = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EV_ONE,
    S_EV_LO,
    S_EV_HI,
    S_EV_DIFF,
    S_EV_MUL,
    S_EV_SUM,
    S_VF_RUN,
    S_VF_DRAIN,
    S_VF_OUT
  } state_t;

  typedef struct packed {
    logic clear;
    logic valid;
  } chk_ctl_t;

  typedef struct packed {
    logic mono;
    logic conc;
  } chk_stat_t;

  // Step count in use: 0 acts as 1, anything above the table size as MAX_STEPS.
  function automatic logic [STEP_W-1:0] eff_steps(input logic [STEP_W-1:0] sc);
    logic [STEP_W-1:0] r;
    if (sc == '0) begin
      r = STEP_W'(1);
    end else if (sc > STEP_W'(MAX_STEPS)) begin
      r = STEP_W'(MAX_STEPS);
    end else begin
      r = sc;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/plmt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module plmt_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/plmt_shape.sv
// Streaming shape checker: monotone and concave tests over a sample stream.
// Depends on plmt_pkg.
`default_nettype none

module plmt_shape (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire plmt_pkg::chk_ctl_t            ctl,
  input  wire logic [plmt_pkg::VAL_W-1:0]    sample,
  input  wire logic [plmt_pkg::TOL_W-1:0]    tol,
  output plmt_pkg::chk_stat_t                stat
);

  logic [plmt_pkg::VAL_W-1:0] prev1;
  logic [plmt_pkg::VAL_W-1:0] prev2;
  logic [1:0]                 seen;   // samples taken, saturates at 2
  logic                       mono;
  logic                       conc;
  logic signed [33:0]         mono_lhs;
  logic signed [33:0]         mono_rhs;
  logic signed [33:0]         conc_lhs;
  logic signed [33:0]         conc_rhs;
  logic                       mono_fail;
  logic                       conc_fail;

  always_comb begin
    mono_lhs  = 34'($signed(prev1)) - $signed({18'b0, tol});
    mono_rhs  = 34'($signed(sample));
    conc_lhs  = 34'($signed(prev2)) + 34'($signed(sample)) - $signed({17'b0, tol, 1'b0});
    conc_rhs  = 34'($signed(prev1)) <<< 1;
    mono_fail = (seen != 2'd0) && (mono_lhs > mono_rhs);
    conc_fail = (seen == 2'd2) && (conc_lhs > conc_rhs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 2'd0;
      mono <= 1'b1;
      conc <= 1'b1;
    end else if (ctl.clear) begin
      seen <= 2'd0;
      mono <= 1'b1;
      conc <= 1'b1;
    end else if (ctl.valid) begin
      if (seen != 2'd2) begin
        seen <= seen + 2'd1;
      end
      if (mono_fail) begin
        mono <= 1'b0;
      end
      if (conc_fail) begin
        conc <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      prev2 <= prev1;
      prev1 <= sample;
    end
  end

  assign stat.mono = mono;
  assign stat.conc = conc;

endmodule

`default_nettype wire

// File: hdl/piecewise_linear_modifier_table.sv
// Top level of the piecewise-linear table: APB registers, command sequencer,
// interpolation datapath. Depends on plmt_pkg, plmt_ram, plmt_shape.
// Per command, from start accepted to the done strobe (busy drops with done):
//   write: no result; evaluate at or above 1.0: result 1.0, no read; evaluate:
//   two reads through the one RAM read port, then subtract, multiply, add;
//   verify: reads samples 0..effective step count (0 counts as 1, above 256 as 256).
// Reset: synchronous; step_count = 256, slack_tol = 7, table undefined.
// Results cannot be stalled: done is high for one cycle per item.
`default_nettype none

module piecewise_linear_modifier_table (
  input  wire logic                clk,
  input  wire logic                rst,
  // command side
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          command,
  input  wire logic [8:0]          entry_index,
  input  wire logic signed [31:0]  entry_value,
  input  wire logic [16:0]         x_in,
  // result side
  output logic                     done,
  output logic signed [31:0]       value_out,
  output logic                     is_monotone,
  output logic                     is_concave,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Register 0 at byte 0, register 1 at byte 4.
  // ---------------------------------------------------------------------------
  logic [plmt_pkg::STEP_W-1:0] step_count;
  logic [plmt_pkg::TOL_W-1:0]  slack_tol;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= plmt_pkg::STEP_W'(plmt_pkg::MAX_STEPS);
      slack_tol  <= plmt_pkg::TOL_W'(7);
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        slack_tol <= pwdata[plmt_pkg::TOL_W-1:0];
      end else begin
        step_count <= pwdata[plmt_pkg::STEP_W-1:0];
      end
    end
  end

  assign prdata = paddr[2] ? {16'b0, slack_tol} : {23'b0, step_count};

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  plmt_pkg::state_t state;
  plmt_pkg::state_t state_next;

  logic                         accept;
  logic [plmt_pkg::STEP_W-1:0]  n_eff;
  logic [plmt_pkg::IDX_W-1:0]   cnt;        // verify read pointer, 0..n
  logic                         rd_valid;   // RAM data of a verify read is valid

  assign busy   = (state != plmt_pkg::S_IDLE);
  assign accept = start && !busy;
  assign n_eff  = plmt_pkg::eff_steps(step_count);

  always_comb begin
    state_next = state;
    case (state)
      plmt_pkg::S_IDLE: begin
        if (accept) begin
          case (command)
            plmt_pkg::CMD_EVAL: begin
              state_next = x_in[plmt_pkg::FRAC_BITS] ? plmt_pkg::S_EV_ONE
                                                     : plmt_pkg::S_EV_LO;
            end
            plmt_pkg::CMD_VERIFY: state_next = plmt_pkg::S_VF_RUN;
            default:              state_next = plmt_pkg::S_IDLE;
          endcase
        end
      end
      plmt_pkg::S_EV_ONE:   state_next = plmt_pkg::S_IDLE;
      plmt_pkg::S_EV_LO:    state_next = plmt_pkg::S_EV_HI;
      plmt_pkg::S_EV_HI:    state_next = plmt_pkg::S_EV_DIFF;
      plmt_pkg::S_EV_DIFF:  state_next = plmt_pkg::S_EV_MUL;
      plmt_pkg::S_EV_MUL:   state_next = plmt_pkg::S_EV_SUM;
      plmt_pkg::S_EV_SUM:   state_next = plmt_pkg::S_IDLE;
      plmt_pkg::S_VF_RUN: begin
        if (cnt == n_eff) begin
          state_next = plmt_pkg::S_VF_DRAIN;
        end
      end
      plmt_pkg::S_VF_DRAIN: state_next = plmt_pkg::S_VF_OUT;
      plmt_pkg::S_VF_OUT:   state_next = plmt_pkg::S_IDLE;
      default:              state_next = plmt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plmt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Interpolation datapath
  // ---------------------------------------------------------------------------
  logic [plmt_pkg::FRAC_BITS-1:0]    x_frac;
  logic [plmt_pkg::P_W-1:0]          p;       // x * N in Q.FRAC_BITS
  logic [plmt_pkg::IDX_W-1:0]        lo;
  logic [plmt_pkg::FRAC_BITS-1:0]    frac;
  logic [plmt_pkg::VAL_W-1:0]        a;
  logic signed [plmt_pkg::DIFF_W-1:0] diff;
  logic signed [plmt_pkg::PROD_W-1:0] prod;
  logic [plmt_pkg::VAL_W-1:0]        interp;
  logic [plmt_pkg::VAL_W-1:0]        rdata;

  assign p = plmt_pkg::P_W'(x_frac) * plmt_pkg::P_W'(n_eff);

  // floor((b-a)*f / 2^FRAC_BITS) is the arithmetic shift, i.e. the upper bits
  assign interp = a + plmt_pkg::VAL_W'(prod[plmt_pkg::PROD_W-1:plmt_pkg::FRAC_BITS]);

  // ---------------------------------------------------------------------------
  // Output decode
  // ---------------------------------------------------------------------------
  logic                       ram_we;
  logic [plmt_pkg::IDX_W-1:0] raddr;
  logic                       load_x;
  logic                       load_lo;
  logic                       load_a;
  logic                       load_diff;
  logic                       load_prod;
  logic                       emit_one;
  logic                       emit_eval;
  logic                       emit_verify;
  logic                       cnt_inc;
  plmt_pkg::chk_ctl_t         chk_ctl;
  plmt_pkg::chk_stat_t        chk_stat;

  always_comb begin
    ram_we        = 1'b0;
    raddr         = lo;
    load_x        = 1'b0;
    load_lo       = 1'b0;
    load_a        = 1'b0;
    load_diff     = 1'b0;
    load_prod     = 1'b0;
    emit_one      = 1'b0;
    emit_eval     = 1'b0;
    emit_verify   = 1'b0;
    cnt_inc       = 1'b0;
    chk_ctl.clear = 1'b0;
    chk_ctl.valid = rd_valid;
    case (state)
      plmt_pkg::S_IDLE: begin
        if (accept) begin
          case (command)
            plmt_pkg::CMD_WRITE: begin
              ram_we = (entry_index <= plmt_pkg::IDX_W'(plmt_pkg::MAX_STEPS));
            end
            plmt_pkg::CMD_EVAL:   load_x = 1'b1;
            plmt_pkg::CMD_VERIFY: chk_ctl.clear = 1'b1;
            default: begin
            end
          endcase
        end
      end
      plmt_pkg::S_EV_ONE: emit_one = 1'b1;
      plmt_pkg::S_EV_LO: begin
        raddr   = p[plmt_pkg::P_W-1:plmt_pkg::FRAC_BITS];
        load_lo = 1'b1;
      end
      plmt_pkg::S_EV_HI: begin
        raddr  = lo + plmt_pkg::IDX_W'(1);
        load_a = 1'b1;
      end
      plmt_pkg::S_EV_DIFF: load_diff = 1'b1;
      plmt_pkg::S_EV_MUL:  load_prod = 1'b1;
      plmt_pkg::S_EV_SUM:  emit_eval = 1'b1;
      plmt_pkg::S_VF_RUN: begin
        raddr   = cnt;
        cnt_inc = 1'b1;
      end
      plmt_pkg::S_VF_OUT: emit_verify = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_x) begin
      x_frac <= x_in[plmt_pkg::FRAC_BITS-1:0];
    end
    if (load_lo) begin
      lo   <= p[plmt_pkg::P_W-1:plmt_pkg::FRAC_BITS];
      frac <= p[plmt_pkg::FRAC_BITS-1:0];
    end
    if (load_a) begin
      a <= rdata;
    end
    if (load_diff) begin
      diff <= plmt_pkg::DIFF_W'($signed(rdata)) - plmt_pkg::DIFF_W'($signed(a));
    end
    if (load_prod) begin
      prod <= plmt_pkg::PROD_W'(diff * $signed({1'b0, frac}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cnt_inc;
      if (chk_ctl.clear) begin
        cnt <= '0;
      end else if (cnt_inc) begin
        cnt <= cnt + plmt_pkg::IDX_W'(1);
      end
    end
  end

  plmt_ram #(
    .DEPTH (plmt_pkg::DEPTH),
    .WIDTH (plmt_pkg::VAL_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry_index),
    .wdata (entry_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  plmt_shape u_shape (
    .clk    (clk),
    .rst    (rst),
    .ctl    (chk_ctl),
    .sample (rdata),
    .tol    (slack_tol),
    .stat   (chk_stat)
  );

  // ---------------------------------------------------------------------------
  // Result register: one strobe per evaluate or verify item
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= emit_one || emit_eval || emit_verify;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_one) begin
      value_out   <= plmt_pkg::ONE_Q;
      is_monotone <= 1'b0;
      is_concave  <= 1'b0;
    end else if (emit_eval) begin
      value_out   <= interp;
      is_monotone <= 1'b0;
      is_concave  <= 1'b0;
    end else if (emit_verify) begin
      value_out   <= '0;
      is_monotone <= chk_stat.mono;
      is_concave  <= chk_stat.conc;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done strobe lasted more than one cycle");

  a_sum_emits: assert property (@(posedge clk) disable iff (rst)
    (state == plmt_pkg::S_EV_SUM) |=> done && !busy)
    else $error("evaluate finished without a result");

  a_drain_has_data: assert property (@(posedge clk) disable iff (rst)
    (state == plmt_pkg::S_VF_DRAIN) |-> rd_valid)
    else $error("verify drain without pending sample");

  a_verify_zero_value: assert property (@(posedge clk) disable iff (rst)
    (done && (is_monotone || is_concave)) |-> (value_out == '0))
    else $error("verify item carried a nonzero value");

endmodule

`default_nettype wire

// File: verif/piecewise_linear_modifier_table_tb.sv
// Self-checking testbench for piecewise_linear_modifier_table: drives commands and
// APB register writes, predicts every result in a small scoreboard class.
// Depends on plmt_pkg and the piecewise_linear_modifier_table RTL.
`timescale 1ns / 1ps

module piecewise_linear_modifier_table_tb;

  localparam int HALF_PERIOD   = 5;
  localparam int ITEMS         = 850;
  localparam int SETTLE_CYCLES = 8;        // covers a trailing write, which has no done
  localparam int DRAIN_LIMIT   = 2000;
  localparam int CYCLE_LIMIT   = 2_000_000;

  // Register indexes; byte address is 4 * index.
  localparam int REG_STEP_COUNT = 0;
  localparam int REG_TOLERANCE  = 1;

  // Command 3 has no package name; the block ignores it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic signed [31:0] value;
    logic               mono;
    logic               conc;
  } lut_result_t;

  // Own copy of table and registers; turns each accepted item into the
  // result it should produce and checks results in arrival order.
  class lut_scoreboard;
    logic [8:0]         step_count;
    logic [15:0]        tolerance;
    logic signed [31:0] samples [0:plmt_pkg::MAX_STEPS];
    lut_result_t        pending [$];
    int                 errors;

    function new();
      step_count = 9'd256;
      tolerance  = 16'd7;
      errors     = 0;
    endfunction

    function void write_reg(int reg_idx, logic [31:0] data);
      if (reg_idx == REG_STEP_COUNT) begin
        step_count = data[8:0];
      end else if (reg_idx == REG_TOLERANCE) begin
        tolerance = data[15:0];
      end
    endfunction

    // 0 behaves as one segment, anything past the table as the full table
    function int steps_in_use();
      if (step_count == 0) begin
        return 1;
      end else if (step_count > plmt_pkg::MAX_STEPS) begin
        return plmt_pkg::MAX_STEPS;
      end
      return int'(step_count);
    endfunction

    function void note_item(logic [1:0] cmd, logic [8:0] idx, logic signed [31:0] val,
                            logic [16:0] x);
      lut_result_t r;
      longint      n, p, seg, f, a, b, tol, pair;
      int          i;
      r.value = '0;
      r.mono  = 1'b0;
      r.conc  = 1'b0;
      n   = steps_in_use();
      tol = longint'(tolerance);
      if (cmd == plmt_pkg::CMD_WRITE) begin
        if (idx <= plmt_pkg::MAX_STEPS) begin
          samples[idx] = val;
        end
      end else if (cmd == plmt_pkg::CMD_EVAL) begin
        if (longint'(x) >= (longint'(1) << plmt_pkg::FRAC_BITS)) begin
          r.value = 32'sd1 <<< plmt_pkg::FRAC_BITS;       // clamped at 1.0, exact
        end else begin
          p   = longint'(x) * n;
          seg = p >>> plmt_pkg::FRAC_BITS;
          f   = p & ((longint'(1) << plmt_pkg::FRAC_BITS) - 1);
          if (seg >= n) begin
            seg = n - 1;
          end
          a = longint'(samples[seg]);
          b = longint'(samples[seg + 1]);
          // arithmetic shift of a signed product floors toward minus infinity
          r.value = 32'(a + (((b - a) * f) >>> plmt_pkg::FRAC_BITS));
        end
        pending.push_back(r);
      end else if (cmd == plmt_pkg::CMD_VERIFY) begin
        r.mono = 1'b1;
        r.conc = 1'b1;
        for (i = 0; i < n; i++) begin
          if (longint'(samples[i]) - tol > longint'(samples[i + 1])) begin
            r.mono = 1'b0;
          end
        end
        for (i = 0; i + 1 < n; i++) begin
          pair = longint'(samples[i]) + longint'(samples[i + 2]);
          if (pair - 2 * tol > 2 * longint'(samples[i + 1])) begin
            r.conc = 1'b0;
          end
        end
        pending.push_back(r);
      end
    endfunction

    function void check_result(logic signed [31:0] value, logic mono, logic conc);
      lut_result_t want;
      if (pending.size() == 0) begin
        $error("result with no item pending: value_out %0d", value);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (value !== want.value) begin
        $error("value_out mismatch: expected %0d, got %0d", want.value, value);
        errors++;
      end
      if (mono !== want.mono) begin
        $error("is_monotone mismatch: expected %0b, got %0b", want.mono, mono);
        errors++;
      end
      if (conc !== want.conc) begin
        $error("is_concave mismatch: expected %0b, got %0b", want.conc, conc);
        errors++;
      end
    endfunction

    function void check_drained();
      if (pending.size() != 0) begin
        $error("%0d expected results never arrived", pending.size());
        errors++;
      end
    endfunction
  endclass

  // DUT signals; all inputs known from time zero
  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               start       = 1'b0;
  logic               busy;
  logic [1:0]         command     = plmt_pkg::CMD_WRITE;
  logic [8:0]         entry_index = '0;
  logic signed [31:0] entry_value = '0;
  logic [16:0]        x_in        = '0;
  logic               done;
  logic signed [31:0] value_out;
  logic               is_monotone;
  logic               is_concave;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [2:0]         paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;

  lut_scoreboard sb;
  int            items_done  = 0;
  int            idle_pct    = 7;
  int            filled_upto = -1;     // samples 0..filled_upto were all written
  int            cycles      = 0;

  piecewise_linear_modifier_table uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .x_in        (x_in),
    .done        (done),
    .value_out   (value_out),
    .is_monotone (is_monotone),
    .is_concave  (is_concave),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // Results can't be stalled: sample on every edge. Reads right after the
  // edge see pre-edge values since the DUT updates in the NBA region.
  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result(value_out, is_monotone, is_concave);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // One command item. Random idle gap first (sender pacing), then start is
  // held until an edge with busy low takes the item.
  task automatic issue(logic [1:0] cmd, logic [8:0] idx, logic signed [31:0] val,
                       logic [16:0] x);
    idle_pct = (items_done < ITEMS / 3) ? 7 : (items_done < 2 * ITEMS / 3) ? 53 : 0;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    command     <= cmd;
    entry_index <= idx;
    entry_value <= val;
    x_in        <= x;
    do @(posedge clk); while (busy);
    sb.note_item(cmd, idx, val, x);
    // ignored items don't count toward the stimulus length
    if (!(cmd == CMD_UNUSED || (cmd == plmt_pkg::CMD_WRITE && idx > plmt_pkg::MAX_STEPS))) begin
      items_done++;
    end
  endtask

  // APB write: setup cycle, then access until pready. The caller drops psel
  // after its last write, so back-to-back writes keep psel high.
  task automatic reg_write(int reg_idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * reg_idx);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(reg_idx, data);
  endtask

  // Registers change only with the block idle: all results in, then a
  // settle wait for a trailing write that gives no done.
  task automatic configure(logic [8:0] steps, logic [15:0] tol);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    reg_write(REG_STEP_COUNT, 32'(steps));
    reg_write(REG_TOLERANCE, 32'(tol));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Fill samples 0..N with a table shape. Mostly rising concave curves,
  // some placed right at the monotone or concave slack, some falling lines,
  // some noise.
  task automatic load_shape();
    int                 n, kind, j;
    longint             v, d, tol;
    logic signed [31:0] vals [0:plmt_pkg::MAX_STEPS];
    n    = sb.steps_in_use();
    tol  = longint'(sb.tolerance);
    kind = $urandom_range(9);
    v    = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
    if (kind == 8) begin
      d = longint'($urandom_range(0, 32'(2 * tol + 2)));
    end else begin
      d = longint'($urandom_range(0, 1 << 17));
    end
    for (j = 0; j <= n; j++) begin
      if (kind == 9) begin
        vals[j] = $urandom;
      end else if (kind == 8) begin
        vals[j] = 32'(v);
        v = v - d;
      end else begin
        vals[j] = 32'(v);
        v = v + d;
        d = d - longint'($urandom_range(0, 32'(d / 4)));   // shrinking slope
      end
    end
    // one drop of slack-1, slack or slack+1
    if (kind == 6) begin
      j = $urandom_range(1, n);
      vals[j] = 32'(longint'(vals[j - 1]) - tol - (longint'($urandom_range(0, 2)) - 1));
    end
    // one sag around the concavity slack
    if (kind == 7 && n >= 2) begin
      j = $urandom_range(1, n - 1);
      vals[j] = 32'(((longint'(vals[j - 1]) + longint'(vals[j + 1])) >>> 1) - tol
                    + (longint'($urandom_range(0, 2)) - 1));
    end
    for (j = 0; j <= n; j++) begin
      issue(plmt_pkg::CMD_WRITE, 9'(j), vals[j], 17'($urandom));
    end
    if (n > filled_upto) begin
      filled_upto = n;
    end
  endtask

  initial begin
    int                 phase, k, n, sel, idx;
    logic [8:0]         steps;
    logic [15:0]        tol;
    logic [16:0]        x;
    logic signed [31:0] val;

    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // Reset config, table empty: only the clamped evaluate is allowed.
    issue(plmt_pkg::CMD_EVAL, 9'($urandom), $urandom, 17'd65536);
    issue(plmt_pkg::CMD_EVAL, 9'($urandom), $urandom, 17'h1FFFF);
    issue(CMD_UNUSED, 9'($urandom), $urandom, 17'($urandom));
    issue(plmt_pkg::CMD_WRITE, 9'd511, $urandom, 17'($urandom));      // index past the table
    issue(plmt_pkg::CMD_WRITE, 9'd257, $urandom, 17'($urandom));

    // Single segment, zero slack, full-range samples both ways.
    configure(9'd1, 16'd0);
    issue(plmt_pkg::CMD_WRITE, 9'd0, 32'h8000_0000, 17'($urandom));
    issue(plmt_pkg::CMD_WRITE, 9'd1, 32'h7FFF_FFFF, 17'($urandom));
    issue(plmt_pkg::CMD_EVAL, 9'($urandom), $urandom, 17'd0);
    issue(plmt_pkg::CMD_EVAL, 9'($urandom), $urandom, 17'd65535);
    issue(plmt_pkg::CMD_EVAL, 9'($urandom), $urandom, 17'd32768);
    issue(plmt_pkg::CMD_VERIFY, 9'($urandom), $urandom, 17'($urandom));
    issue(plmt_pkg::CMD_WRITE, 9'd0, 32'h7FFF_FFFF, 17'($urandom));
    issue(plmt_pkg::CMD_WRITE, 9'd1, 32'h8000_0000, 17'($urandom));
    issue(plmt_pkg::CMD_EVAL, 9'($urandom), $urandom, 17'd1);         // negative slope, floor
    issue(plmt_pkg::CMD_VERIFY, 9'($urandom), $urandom, 17'($urandom));

    // Two segments, widest slack, convex table.
    configure(9'd2, 16'hFFFF);
    issue(plmt_pkg::CMD_WRITE, 9'd0, 32'sh0000_0000, 17'($urandom));
    issue(plmt_pkg::CMD_WRITE, 9'd1, 32'sh0001_0000, 17'($urandom));
    issue(plmt_pkg::CMD_WRITE, 9'd2, 32'sh0004_0000, 17'($urandom));
    issue(plmt_pkg::CMD_VERIFY, 9'($urandom), $urandom, 17'($urandom));
    issue(plmt_pkg::CMD_EVAL, 9'($urandom), $urandom, 17'd65535);
    issue(plmt_pkg::CMD_EVAL, 9'($urandom), $urandom, 17'd32768);

    // Step count 0 acts as one segment.
    configure(9'd0, 16'hFFFF);
    issue(plmt_pkg::CMD_VERIFY, 9'($urandom), $urandom, 17'($urandom));
    issue(plmt_pkg::CMD_EVAL, 9'($urandom), $urandom, 17'd40000);
    filled_upto = 2;

    // ---- random phases ----
    phase = 0;
    while (items_done < ITEMS) begin
      case (phase)
        0: begin
          steps = 9'd256;
          tol   = 16'd7;
        end
        1: begin
          steps = 9'd1;
          tol   = 16'hFFFF;
        end
        2: begin
          steps = 9'd0;
          tol   = 16'd0;
        end
        3: begin
          steps = 9'd400;       // above the table, acts as full size
          tol   = 16'd0;
        end
        default: begin
          // mostly small tables; full-size ones are slow to verify
          sel = $urandom_range(19);
          if (sel == 0) begin
            steps = 9'($urandom_range(257, 511));
          end else if (sel == 1) begin
            steps = 9'd256;
          end else if (sel == 2) begin
            steps = 9'($urandom_range(0, 1));
          end else begin
            steps = 9'($urandom_range(2, 24));
          end
          sel = $urandom_range(4);
          case (sel)
            0:       tol = 16'd0;
            1:       tol = 16'hFFFF;
            2:       tol = 16'd7;
            3:       tol = 16'($urandom_range(0, 64));
            default: tol = 16'($urandom);
          endcase
        end
      endcase
      configure(steps, tol);
      n = sb.steps_in_use();
      if (n <= 32 || filled_upto < n) begin
        load_shape();
      end
      issue(plmt_pkg::CMD_VERIFY, 9'($urandom), $urandom, 17'($urandom));

      for (k = $urandom_range(25, 50); k > 0; k--) begin
        sel = $urandom_range(99);
        if (sel < 12) begin
          // sample rewrite: a nudge around the slack or a full-range value
          idx = ($urandom_range(9) == 0) ? $urandom_range(257, 511) : $urandom_range(0, 256);
          if (idx <= filled_upto && $urandom_range(1) == 1) begin
            val = 32'(longint'(sb.samples[idx])
                      + longint'($urandom_range(0, 32'(2 * sb.tolerance + 4)))
                      - longint'(sb.tolerance) - 2);
          end else begin
            val = $urandom;
          end
          issue(plmt_pkg::CMD_WRITE, 9'(idx), val, 17'($urandom));
        end else if (sel < 72) begin
          case ($urandom_range(9))
            0: begin
              case ($urandom_range(3))
                0:       x = 17'd0;
                1:       x = 17'd65535;
                2:       x = 17'd65536;
                default: x = 17'h1FFFF;
              endcase
            end
            1:       x = 17'($urandom_range(65536, 131071));
            2:       x = 17'(($urandom_range(0, n - 1) << plmt_pkg::FRAC_BITS) / n);  // near a knot
            default: x = 17'($urandom_range(0, 65535));
          endcase
          issue(plmt_pkg::CMD_EVAL, 9'($urandom), $urandom, x);
        end else if (sel < 92) begin
          issue(plmt_pkg::CMD_VERIFY, 9'($urandom), $urandom, 17'($urandom));
        end else begin
          issue(CMD_UNUSED, 9'($urandom), $urandom, 17'($urandom));
        end
      end
      phase++;
    end

    // ---- drain and report ----
    start <= 1'b0;
    for (k = 0; k < DRAIN_LIMIT && sb.pending.size() != 0; k++) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/plmt_pkg.sv
hdl/plmt_ram.sv
hdl/plmt_shape.sv
hdl/piecewise_linear_modifier_table.sv
verif/piecewise_linear_modifier_table_tb.sv
